// File: src/sdfc_pkg.sv
package sdfc_pkg;

  localparam int unsigned LINE_DEPTH_DEF  = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned FEEDBACK_W = 16;
  localparam int unsigned DAMPING_W  = 17;
  localparam int unsigned COEF_SHIFT = 16;

  localparam logic [FEEDBACK_W-1:0] FEEDBACK_MAX = 16'd64880;
  localparam logic [DAMPING_W-1:0]  DAMPING_ONE  = 17'd65536;
  localparam int unsigned           DELAY_RESET  = 4410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_DAMPING_COEFF = 2'd2,
    REG_MONO_INPUT    = 2'd3
  } cfg_reg_e;

endpackage

// File: src/sdfc_if.sv
interface sdfc_in_if #(
  parameter int unsigned SAMPLE_BITS = sdfc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface sdfc_out_if #(
  parameter int unsigned SAMPLE_BITS = sdfc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

interface sdfc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sdfc_pkg::CFG_IDX_W-1:0]      index;
  logic [sdfc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/stereo_damped_feedback_comb_unit.sv
// Stereo lowpass-feedback comb filter. Each accepted request carries one stereo
// pair and yields one stereo result, the new one-pole lowpass state of each channel,
// after the delayed sample has been damped and the input plus scaled feedback has been
// written back into the delay line. A single multiplier is shared over three products
// per channel under a small sequencer, so each pair passes through acceptance, five
// steps per channel and one step to hand the result to the output register before the
// input is ready again; a result waiting at the output only holds the block when the
// next result is finished. The delay lines need no clearing pass after reset: a fill mark
// tracks how far the lines have been written, and cells at or above it read as zero. A
// write of delay_length that leaves the ring position at or above the new length runs a
// bit-serial remainder of the ring position over its address bits, during which neither
// the input nor the configuration port is ready.
module stereo_damped_feedback_comb_unit #(
  parameter int unsigned LINE_DEPTH  = sdfc_pkg::LINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = sdfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdfc_in_if.sink     in_chan,
  sdfc_out_if.source  out_chan,
  sdfc_cfg_if.sink    cfg_chan
);

  localparam int unsigned AW    = $clog2(LINE_DEPTH);
  localparam int unsigned LW    = $clog2(LINE_DEPTH + 1);
  localparam int unsigned CNT_W = $clog2(AW + 1);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PW    = SB + sdfc_pkg::DAMPING_W + 1;
  localparam int unsigned SW    = PW - sdfc_pkg::COEF_SHIFT;
  localparam int unsigned EW    = SB + 3;
  localparam int unsigned CMP_W = (LW > sdfc_pkg::CFG_DATA_W) ? LW : sdfc_pkg::CFG_DATA_W;
  localparam int unsigned LEN_RST =
    (sdfc_pkg::DELAY_RESET > LINE_DEPTH) ? LINE_DEPTH : sdfc_pkg::DELAY_RESET;

  localparam logic [CMP_W-1:0]     DEPTH_C = CMP_W'(LINE_DEPTH);
  localparam logic signed [EW-1:0] SAT_HI  = {4'b0000, {(SB-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO  = {4'b1111, {(SB-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL_DLY = 8'b0000_0010,
    ST_MUL_SMO = 8'b0000_0100,
    ST_SUM     = 8'b0000_1000,
    ST_MUL_FB  = 8'b0001_0000,
    ST_WRITE   = 8'b0010_0000,
    ST_DONE    = 8'b0100_0000,
    ST_MOD     = 8'b1000_0000
  } state_e;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [EW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  function automatic logic cfg_reg_is_len();
    return sdfc_pkg::cfg_reg_e'(cfg_chan.index) == sdfc_pkg::REG_DELAY_LENGTH;
  endfunction

  state_e state_q, state_d;

  logic [LW-1:0]                   len_q;
  logic [sdfc_pkg::FEEDBACK_W-1:0] fb_q;
  logic [sdfc_pkg::DAMPING_W-1:0]  damp_q;
  logic                            mono_q;

  logic [AW-1:0]        pos_q;
  logic [LW-1:0]        mark_q;
  logic                 ch_q;
  logic signed [SB-1:0] smooth_l_q, smooth_r_q;
  logic                 out_valid_q;

  logic [LW-1:0]        rem_q;
  logic [AW-1:0]        pos_sh_q;
  logic [CNT_W-1:0]     cnt_q;

  logic signed [SB-1:0] x_l_q, x_r_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] acc_q;
  logic signed [SB-1:0] out_l_q, out_r_q;
  logic signed [SB-1:0] rd_l_q, rd_r_q;

  logic signed [SB-1:0] line_l_mem [LINE_DEPTH];
  logic signed [SB-1:0] line_r_mem [LINE_DEPTH];

  logic                            in_fire, cfg_fire, out_free;
  logic                            rd_valid;
  logic signed [SB-1:0]            delayed, smooth_cur, x_cur;
  logic signed [SB-1:0]            mul_a;
  logic [sdfc_pkg::DAMPING_W-1:0]  mul_b;
  logic signed [PW-1:0]            prod_d;
  logic signed [SW-1:0]            prod_sh;
  logic signed [EW-1:0]            smooth_sum, line_sum;
  logic signed [SB-1:0]            smooth_new, line_new;
  logic                            wr_l, wr_r;
  logic [CMP_W-1:0]                len_raw;
  logic [LW-1:0]                   len_new;
  logic [LW:0]                     mod_t, mod_r;
  logic [LW-1:0]                   pos_inc;

  assign in_chan.ready  = state_q == ST_IDLE && !cfg_chan.valid;
  assign cfg_chan.ready = state_q == ST_IDLE;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;
  assign out_free       = !out_valid_q || out_chan.ready;

  assign out_chan.valid     = out_valid_q;
  assign out_chan.out_left  = out_l_q;
  assign out_chan.out_right = out_r_q;

  // delay length clamp to 1..LINE_DEPTH
  always_comb begin
    len_raw = CMP_W'(cfg_chan.data);
    if (len_raw == '0) begin
      len_raw = CMP_W'(1);
    end else if (len_raw > DEPTH_C) begin
      len_raw = DEPTH_C;
    end
    len_new = len_raw[LW-1:0];
  end

  // cells at or above the fill mark were never written since reset or a shrink
  assign rd_valid   = LW'(pos_q) < mark_q;
  assign delayed    = rd_valid ? (ch_q ? rd_r_q : rd_l_q) : '0;
  assign smooth_cur = ch_q ? smooth_r_q : smooth_l_q;
  assign x_cur      = ch_q ? x_r_q : x_l_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_DLY: begin
        mul_a = delayed;
        mul_b = sdfc_pkg::DAMPING_ONE - damp_q;
      end
      ST_MUL_SMO: begin
        mul_a = smooth_cur;
        mul_b = damp_q;
      end
      ST_MUL_FB: begin
        mul_a = smooth_cur;
        mul_b = sdfc_pkg::DAMPING_W'(fb_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d     = mul_a * $signed({1'b0, mul_b});
  assign prod_sh    = $signed(prod_q[PW-1:sdfc_pkg::COEF_SHIFT]);
  assign smooth_sum = EW'(acc_q) + EW'(prod_sh);
  assign line_sum   = EW'(x_cur) + EW'(prod_sh);
  assign smooth_new = sat_sample(smooth_sum);
  assign line_new   = sat_sample(line_sum);

  assign wr_l = state_q == ST_WRITE && !ch_q;
  assign wr_r = state_q == ST_WRITE && ch_q;

  assign mod_t   = {rem_q, pos_sh_q[AW-1]};
  assign mod_r   = (mod_t >= {1'b0, len_q}) ? mod_t - {1'b0, len_q} : mod_t;
  assign pos_inc = LW'(pos_q) + LW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg_reg_is_len() && len_new != len_q && LW'(pos_q) >= len_new) begin
            state_d = ST_MOD;
          end
        end else if (in_fire) begin
          state_d = ST_MUL_DLY;
        end
      end
      ST_MUL_DLY: state_d = ST_MUL_SMO;
      ST_MUL_SMO: state_d = ST_SUM;
      ST_SUM:     state_d = ST_MUL_FB;
      ST_MUL_FB:  state_d = ST_WRITE;
      ST_WRITE:   state_d = ch_q ? ST_DONE : ST_MUL_DLY;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LW'(LEN_RST);
      fb_q        <= '0;
      damp_q      <= '0;
      mono_q      <= 1'b0;
      pos_q       <= '0;
      mark_q      <= '0;
      ch_q        <= 1'b0;
      smooth_l_q  <= '0;
      smooth_r_q  <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      pos_sh_q    <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_chan.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (cfg_fire) begin
            case (sdfc_pkg::cfg_reg_e'(cfg_chan.index))
              sdfc_pkg::REG_DELAY_LENGTH: begin
                if (len_new != len_q) begin
                  len_q <= len_new;
                  if (len_new < mark_q) begin
                    mark_q <= len_new;
                  end
                  rem_q    <= '0;
                  pos_sh_q <= pos_q;
                  cnt_q    <= CNT_W'(AW - 1);
                end
              end
              sdfc_pkg::REG_FEEDBACK_GAIN: begin
                fb_q <= (cfg_chan.data[sdfc_pkg::FEEDBACK_W-1:0] > sdfc_pkg::FEEDBACK_MAX) ?
                        sdfc_pkg::FEEDBACK_MAX : cfg_chan.data[sdfc_pkg::FEEDBACK_W-1:0];
              end
              sdfc_pkg::REG_DAMPING_COEFF: begin
                damp_q <= (cfg_chan.data[sdfc_pkg::DAMPING_W-1:0] > sdfc_pkg::DAMPING_ONE) ?
                          sdfc_pkg::DAMPING_ONE : cfg_chan.data[sdfc_pkg::DAMPING_W-1:0];
              end
              sdfc_pkg::REG_MONO_INPUT: begin
                mono_q <= cfg_chan.data[0];
              end
              default: begin
                mono_q <= mono_q;
              end
            endcase
          end else if (in_fire) begin
            ch_q <= 1'b0;
          end
        end
        ST_SUM: begin
          if (ch_q) begin
            smooth_r_q <= smooth_new;
          end else begin
            smooth_l_q <= smooth_new;
          end
        end
        ST_WRITE: begin
          ch_q <= 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            if (LW'(pos_q) == mark_q) begin
              mark_q <= mark_q + LW'(1);
            end
            pos_q <= (pos_inc == len_q) ? '0 : pos_inc[AW-1:0];
          end
        end
        ST_MOD: begin
          rem_q    <= mod_r[LW-1:0];
          pos_sh_q <= pos_sh_q << 1;
          cnt_q    <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            pos_q <= mod_r[AW-1:0];
          end
        end
        default: begin
          ch_q <= ch_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == ST_MUL_SMO) begin
      acc_q <= prod_sh;
    end
    if (in_fire) begin
      x_l_q <= in_chan.in_left;
      x_r_q <= mono_q ? in_chan.in_left : in_chan.in_right;
    end
    if (state_q == ST_DONE && out_free) begin
      out_l_q <= smooth_l_q;
      out_r_q <= smooth_r_q;
    end
  end

  // delay lines
  always_ff @(posedge clk_i) begin
    if (wr_l) begin
      line_l_mem[pos_q] <= line_new;
    end
    rd_l_q <= line_l_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_r) begin
      line_r_mem[pos_q] <= line_new;
    end
    rd_r_q <= line_r_mem[pos_q];
  end

endmodule

// File: sim/sdfc_comb_checker.sv
`timescale 1ns / 100ps

module sdfc_comb_checker
  import sdfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sdfc_in_if   in_mon,
  sdfc_out_if  out_mon,
  sdfc_cfg_if  cfg_mon,
  output int   errors_o,
  output int   pending_o
);

  localparam int     SW      = SAMPLE_BITS_DEF;
  localparam int     DEPTH   = LINE_DEPTH_DEF;
  localparam longint PEAK    = (longint'(1) << (SW - 1)) - 1;
  localparam longint UNITY   = longint'(DAMPING_ONE);
  localparam longint FB_CEIL = longint'(FEEDBACK_MAX);

  typedef logic signed [SW-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  sample_t line_mem [2][DEPTH];
  longint  lowpass [2];
  int      ring_pos;
  int      delay_len;
  longint  fb_gain;
  longint  damping;
  logic    mono;
  stereo_t pending_pairs [$];

  function automatic sample_t clip(input longint v);
    if (v > PEAK) return sample_t'(PEAK);
    if (v < -PEAK - 1) return sample_t'(-PEAK - 1);
    return sample_t'(v);
  endfunction

  // one-pole lowpass on the delayed sample, then write back input plus feedback
  function automatic sample_t damp_channel(input int ch, input longint x);
    longint delayed;
    longint s;
    delayed = line_mem[ch][ring_pos];
    s = clip(((delayed * (UNITY - damping)) >>> COEF_SHIFT)
             + ((lowpass[ch] * damping) >>> COEF_SHIFT));
    lowpass[ch] = s;
    line_mem[ch][ring_pos] = clip(x + ((s * fb_gain) >>> COEF_SHIFT));
    return sample_t'(s);
  endfunction

  task automatic predict_damped_pair(input sample_t l, input sample_t r);
    stereo_t e;
    longint  xl;
    longint  xr;
    xl = l;
    xr = mono ? l : r;
    e.left  = damp_channel(0, xl);
    e.right = damp_channel(1, xr);
    ring_pos = (ring_pos + 1) % delay_len;
    pending_pairs.push_back(e);
  endtask

  task automatic apply_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    int n;
    int i;
    case (idx)
      REG_DELAY_LENGTH: begin
        n = int'(val);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        if (n != delay_len) begin
          delay_len = n;
          // cells past the new end come back as zero
          for (i = n; i < DEPTH; i++) begin
            line_mem[0][i] = '0;
            line_mem[1][i] = '0;
          end
          ring_pos = ring_pos % n;
        end
      end
      REG_FEEDBACK_GAIN: begin
        fb_gain = (val[FEEDBACK_W-1:0] > FEEDBACK_MAX) ? FB_CEIL
                                                        : longint'(val[FEEDBACK_W-1:0]);
      end
      REG_DAMPING_COEFF: begin
        damping = (val > DAMPING_ONE) ? UNITY : longint'(val);
      end
      REG_MONO_INPUT: begin
        mono = val[0];
      end
      default: ;
    endcase
  endtask

  task automatic check_pair(input sample_t l, input sample_t r);
    stereo_t e;
    if (pending_pairs.size() == 0) begin
      $display("%0t: result with no request waiting, left %0d right %0d", $time, l, r);
      errors_o++;
    end else begin
      e = pending_pairs.pop_front();
      if (l !== e.left) begin
        $display("%0t: out_left expected %0d got %0d", $time, e.left, l);
        errors_o++;
      end
      if (r !== e.right) begin
        $display("%0t: out_right expected %0d got %0d", $time, e.right, r);
        errors_o++;
      end
    end
  endtask

  task automatic clear_state();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      line_mem[0][i] = '0;
      line_mem[1][i] = '0;
    end
    lowpass[0] = 0;
    lowpass[1] = 0;
    ring_pos   = 0;
    delay_len  = DELAY_RESET;
    fb_gain    = 0;
    damping    = 0;
    mono       = 1'b0;
    pending_pairs.delete();
    errors_o   = 0;
    pending_o  = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (out_mon.valid && out_mon.ready) check_pair(out_mon.out_left, out_mon.out_right);
      if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_reg_e'(cfg_mon.index), cfg_mon.data);
      if (in_mon.valid && in_mon.ready) predict_damped_pair(in_mon.in_left, in_mon.in_right);
      pending_o = pending_pairs.size();
    end
  end

endmodule

// File: sim/stereo_damped_feedback_comb_unit_tb.sv
`timescale 1ns / 100ps

module stereo_damped_feedback_comb_unit_tb;
  import sdfc_pkg::*;

  localparam int SW              = SAMPLE_BITS_DEF;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_PHASES   = 14;
  localparam int PAIRS_PER_PHASE = 50;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles;
  bit   rx_hold_req;
  bit   no_idle;

  sdfc_in_if  in_bus ();
  sdfc_out_if out_bus ();
  sdfc_cfg_if cfg_bus ();

  stereo_damped_feedback_comb_unit uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  sdfc_comb_checker chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .cfg_mon   (cfg_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin : rx_side
    int r;
    int run;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
      end else if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_bus.ready <= 1'b1;
          run = $urandom_range(1, 8);
        end else if (r < 95) begin
          out_bus.ready <= 1'b0;
          run = $urandom_range(1, 4);
        end else begin
          out_bus.ready <= 1'b0;
          run = $urandom_range(20, 80);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return S_MAX;
    if (r < 8) return S_MIN;
    if (r < 11) return '0;
    if (r < 14) return '1;
    return sample_t'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CFG_DATA_W'($urandom_range(1, 16));
    if (r < 75) return CFG_DATA_W'($urandom_range(17, 300));
    if (r < 83) return '0;
    if (r < 88) return CFG_DATA_W'(1);
    if (r < 93) return CFG_DATA_W'(LINE_DEPTH_DEF);
    if (r < 96) return '1;
    return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_feedback();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return CFG_DATA_W'(FEEDBACK_MAX);
    if (r < 40) return CFG_DATA_W'((1 << FEEDBACK_W) - 1);
    return CFG_DATA_W'($urandom_range(0, (1 << FEEDBACK_W) - 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_damping();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return DAMPING_ONE;
    if (r < 38) return '1;
    return CFG_DATA_W'($urandom_range(0, DAMPING_ONE));
  endfunction

  task automatic send_pair(input sample_t l, input sample_t r, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.in_left  <= l;
    in_bus.in_right <= r;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_pairs(input int count);
    int i;
    for (i = 0; i < count; i++) send_pair(pick_sample(), pick_sample(), pick_gap());
  endtask

  initial begin : stimulus
    int ph;
    int i;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.in_left   = '0;
    in_bus.in_right  = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_DELAY_LENGTH;
    cfg_bus.data     = '0;
    rx_hold_req      = 1'b0;
    no_idle          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, lines read zero
    send_pair(S_MAX, S_MIN, pick_gap());
    send_pair(S_MIN, S_MAX, pick_gap());
    drain_results();

    // out of range delay and feedback, saturating sums
    write_reg(REG_DELAY_LENGTH, '0);
    write_reg(REG_FEEDBACK_GAIN, CFG_DATA_W'((1 << FEEDBACK_W) - 1));
    write_reg(REG_DAMPING_COEFF, '0);
    write_reg(REG_MONO_INPUT, '0);
    for (i = 0; i < 3; i++) send_pair(S_MAX, S_MIN, pick_gap());
    send_pair(S_MIN, S_MAX, pick_gap());
    drain_results();

    // damping above one, held lowpass
    write_reg(REG_DAMPING_COEFF, '1);
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(3));
    send_pair(S_MAX, '1, pick_gap());
    send_pair('0, S_MIN, pick_gap());
    send_pair(S_MIN, S_MAX, pick_gap());
    drain_results();

    // mono, half damping, delay above depth
    write_reg(REG_MONO_INPUT, CFG_DATA_W'(1));
    write_reg(REG_DAMPING_COEFF, DAMPING_ONE >> 1);
    write_reg(REG_DELAY_LENGTH, '1);
    send_pair(S_MIN, S_MAX, pick_gap());
    send_pair(S_MAX, '0, pick_gap());
    send_pair('1, S_MAX, pick_gap());
    drain_results();

    // shrink then regrow the line, same length rewritten
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(8));
    write_reg(REG_FEEDBACK_GAIN, CFG_DATA_W'(40000));
    write_reg(REG_DAMPING_COEFF, '0);
    write_reg(REG_MONO_INPUT, '0);
    send_random_pairs(6);
    drain_results();
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(3));
    send_random_pairs(2);
    drain_results();
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(3));
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(8));
    send_random_pairs(4);
    drain_results();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_DELAY_LENGTH, pick_delay());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FEEDBACK_GAIN, pick_feedback());
      if ($urandom_range(0, 3) != 0) write_reg(REG_DAMPING_COEFF, pick_damping());
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_MONO_INPUT, CFG_DATA_W'($urandom_range(0, 1)));
      end
      no_idle = (ph == 5);
      if (ph == 2) begin
        // receiver stalls long while requests keep coming
        rx_hold_req = 1'b1;
        for (i = 0; i < 12; i++) send_pair(pick_sample(), pick_sample(), 0);
        send_random_pairs(PAIRS_PER_PHASE - 12);
      end else if (ph == 8) begin
        send_random_pairs(PAIRS_PER_PHASE / 2);
        drain_results();
        send_random_pairs(PAIRS_PER_PHASE - PAIRS_PER_PHASE / 2);
      end else begin
        send_random_pairs(PAIRS_PER_PHASE);
      end
      drain_results();
      no_idle = 1'b0;
    end

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
